/* rtl/core/bitmap_index_allocator_macros.svh */
// Assertion macros shared by the checker of the bitmap index allocator.
`ifndef BITMAP_INDEX_ALLOCATOR_MACROS_SVH
`define BITMAP_INDEX_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BIA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bia: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BIA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bia: next-cycle check failed");

`endif

/* rtl/core/bia_pkg.sv */
package bia_pkg;

    localparam int CAPACITY  = 1024;
    localparam int WORD_BITS = 64;
    localparam int MAP_WORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int WADDR_W   = $clog2(MAP_WORDS);
    localparam int IDX_W     = 10;
    localparam int CNT_W     = 11;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    // Verdict of the word unit on the bitmap word at hand.
    typedef struct packed {
        logic                 found;
        logic                 last;
        logic                 bit_set;
        logic [BIT_W-1:0]     pos;
        logic [WORD_BITS-1:0] new_word;
    } t_unit_res;

endpackage

/* rtl/core/bia_ram.sv */
module bia_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/bia_word_unit.sv */
module bia_word_unit (
    input  logic [bia_pkg::WORD_BITS-1:0] i_word,
    input  logic [bia_pkg::WADDR_W-1:0]   i_word_addr,
    input  logic [bia_pkg::CNT_W-1:0]     i_active,
    input  logic                          i_func,
    input  logic [bia_pkg::BIT_W-1:0]     i_bit_pos,
    output bia_pkg::t_unit_res            o_res
);
    import bia_pkg::*;

    logic [CNT_W:0]       base;
    logic [CNT_W:0]       act_x;
    logic [CNT_W:0]       rem;
    logic [WORD_BITS-1:0] range_mask;
    logic [WORD_BITS-1:0] avail;
    logic [WORD_BITS-1:0] lowest;
    logic [BIT_W-1:0]     pos;

    assign base  = (CNT_W+1)'({i_word_addr, {BIT_W{1'b0}}});
    assign act_x = (CNT_W+1)'(i_active);
    assign rem   = act_x - base;

    // Treat bits at or above the active count as taken.
    always_comb begin
        if (act_x <= base) begin
            range_mask = '0;
        end else if (rem >= (CNT_W+1)'(WORD_BITS)) begin
            range_mask = '1;
        end else begin
            range_mask = ~({WORD_BITS{1'b1}} << rem[BIT_W-1:0]);
        end
    end

    assign avail  = ~i_word & range_mask;
    assign lowest = avail & (~avail + WORD_BITS'(1));

    always_comb begin
        pos = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (lowest[b]) begin
                pos = pos | BIT_W'(b);
            end
        end
    end

    always_comb begin
        o_res.found   = |avail;
        o_res.last    = (base + (CNT_W+1)'(WORD_BITS) >= act_x)
                     || (i_word_addr == WADDR_W'(MAP_WORDS - 1));
        o_res.bit_set = i_word[i_bit_pos];
        o_res.pos     = pos;
        if (i_func == FUNC_ALLOC) begin
            o_res.new_word = i_word | lowest;
        end else begin
            o_res.new_word = i_word & ~(WORD_BITS'(1) << i_bit_pos);
        end
    end

endmodule

/* rtl/core/bitmap_index_allocator.sv */
// First-fit bitmap allocator over up to 1024 entries, kept as sixteen 64-bit
// words in a RAM that reads as all free after reset. Raise start with func and
// entry_index while busy is low; the word is taken at that edge. Exactly one
// result word follows, shown for a single cycle with o_result_valid high; the
// receiver cannot stall it, so sample it on that cycle. A rejected item (free
// beyond the active count, or allocate with no free entry) gives its result in
// the cycle after acceptance and never raises busy. A free that passes the
// range check takes one RAM read, then a bit test and write-back. An allocate
// reads the bitmap words in turn, 1 to 16 of them, up to the first one with a
// clear bit in range; the RAM read port and the word unit handle one word per
// cycle. The next item may be started in the cycle its predecessor's result is
// shown. Write active_count through the config channel only while idle; a start
// in the same cycle wins and holds the write off. Values above 1024 act as 1024.
module bitmap_index_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_func,
    input  logic [bia_pkg::IDX_W-1:0]   i_entry_index,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bia_pkg::CNT_W-1:0]   i_cfg_data,
    output logic                        o_result_valid,
    output logic [1:0]                  o_status,
    output logic [bia_pkg::IDX_W-1:0]   o_result_index,
    output logic [bia_pkg::CNT_W-1:0]   o_free_count
);
    import bia_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state               r_state, n_state;
    logic                 r_func, n_func;
    logic [BIT_W-1:0]     r_bit_pos, n_bit_pos;
    logic [WADDR_W-1:0]   r_word_addr, n_word_addr;
    logic [CNT_W-1:0]     r_used, n_used;
    logic [CNT_W-1:0]     r_active;
    logic [MAP_WORDS-1:0] r_word_valid;
    logic                 r_rd_valid;

    logic                 r_out_valid;
    t_status              r_out_status;
    logic [IDX_W-1:0]     r_out_index;
    logic [CNT_W-1:0]     r_out_free;

    logic [CNT_W-1:0]     act_eff;
    logic [CNT_W-1:0]     free_now;
    logic [CNT_W-1:0]     free_after;
    logic [WORD_BITS-1:0] ram_q;
    logic [WORD_BITS-1:0] word_q;
    logic                 rd_en;
    logic [WADDR_W-1:0]   rd_addr;
    logic                 wr_en;
    logic                 finish;
    t_status              fin_status;
    logic [IDX_W-1:0]     fin_index;
    t_unit_res            unit_res;

    assign busy        = (r_state != S_IDLE);
    // Hold the config write off while an item is taken, so the whole item
    // sees one active count.
    assign o_cfg_ready = ~busy & ~start;

    // Saturate the active count at capacity.
    assign act_eff  = (r_active > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : r_active;
    assign free_now = (act_eff > r_used) ? act_eff - r_used : '0;

    // A word never written since reset reads as all free.
    assign word_q = r_rd_valid ? ram_q : '0;

    bia_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_word_addr),
        .i_wdata (unit_res.new_word),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    bia_word_unit u_word_unit (
        .i_word      (word_q),
        .i_word_addr (r_word_addr),
        .i_active    (act_eff),
        .i_func      (r_func),
        .i_bit_pos   (r_bit_pos),
        .o_res       (unit_res)
    );

    // Sequencer: accept in idle, then test one word for a free or walk the map one word per cycle for an allocate.
    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_bit_pos   = r_bit_pos;
        n_word_addr = r_word_addr;
        n_used      = r_used;
        rd_en       = 1'b0;
        rd_addr     = r_word_addr;
        wr_en       = 1'b0;
        finish      = 1'b0;
        fin_status  = ST_OK;
        fin_index   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_func    = i_func;
                    n_bit_pos = i_entry_index[BIT_W-1:0];
                    if (i_func == FUNC_ALLOC) begin
                        if (free_now == '0) begin
                            finish     = 1'b1;
                            fin_status = ST_FULL;
                        end else begin
                            rd_en       = 1'b1;
                            rd_addr     = '0;
                            n_word_addr = '0;
                            n_state     = S_SCAN;
                        end
                    end else begin
                        if (CNT_W'(i_entry_index) >= act_eff) begin
                            finish     = 1'b1;
                            fin_status = ST_BAD;
                        end else begin
                            rd_en       = 1'b1;
                            rd_addr     = i_entry_index[IDX_W-1:BIT_W];
                            n_word_addr = i_entry_index[IDX_W-1:BIT_W];
                            n_state     = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_func == FUNC_ALLOC) begin
                    if (unit_res.found) begin
                        // Set the lowest free bit and write the word back.
                        wr_en      = 1'b1;
                        n_used     = r_used + CNT_W'(1);
                        finish     = 1'b1;
                        fin_status = ST_OK;
                        fin_index  = {r_word_addr, unit_res.pos};
                        n_state    = S_IDLE;
                    end else if (unit_res.last) begin
                        finish     = 1'b1;
                        fin_status = ST_FULL;
                        n_state    = S_IDLE;
                    end else begin
                        // Advance to the next word.
                        rd_en       = 1'b1;
                        rd_addr     = r_word_addr + WADDR_W'(1);
                        n_word_addr = r_word_addr + WADDR_W'(1);
                    end
                end else begin
                    if (!unit_res.bit_set) begin
                        finish     = 1'b1;
                        fin_status = ST_BAD;
                    end else begin
                        wr_en  = 1'b1;
                        n_used = (r_used != '0) ? r_used - CNT_W'(1) : r_used;
                        finish = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign free_after = (act_eff > n_used) ? act_eff - n_used : '0;

    // State, counters and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_out_valid  <= 1'b0;
            r_func       <= FUNC_ALLOC;
            r_bit_pos    <= '0;
            r_word_addr  <= '0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_func      <= n_func;
            r_bit_pos   <= n_bit_pos;
            r_word_addr <= n_word_addr;
            r_out_valid <= finish;
            if (finish) begin
                r_out_status <= fin_status;
                r_out_index  <= fin_index;
                r_out_free   <= free_after;
            end
        end
    end

    // Per-word valid bits stand in for clearing the RAM at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_valid <= '0;
            r_rd_valid   <= 1'b0;
        end else begin
            if (wr_en) begin
                r_word_valid[r_word_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_valid <= r_word_valid[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= CNT_W'(CAPACITY);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_active <= i_cfg_data;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_status       = r_out_status;
    assign o_result_index = r_out_index;
    assign o_free_count   = r_out_free;

endmodule

/* rtl/core/bia_checker.sv */
`include "bitmap_index_allocator_macros.svh"

module bia_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_result_valid,
    input logic [1:0]                  o_status,
    input logic [bia_pkg::IDX_W-1:0]   o_result_index,
    input logic [bia_pkg::CNT_W-1:0]   o_free_count
);
    import bia_pkg::*;

    // An accepted word either occupies the block or answers at once.
    `BIA_ASSERT_NXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_result_valid)
    // Results only appear once the sequencer is back in idle.
    `BIA_ASSERT_IMP(a_result_idle, i_clk, i_rst_n, o_result_valid, !busy)
    // A failed operation reports index zero.
    `BIA_ASSERT_IMP(a_fail_index, i_clk, i_rst_n,
        o_result_valid && (o_status != ST_OK), o_result_index == '0)
    // No free entry means the free count is zero.
    `BIA_ASSERT_IMP(a_full_count, i_clk, i_rst_n,
        o_result_valid && (o_status == ST_FULL), o_free_count == '0)
    // Free count never exceeds capacity.
    `BIA_ASSERT_IMP(a_free_range, i_clk, i_rst_n,
        o_result_valid, o_free_count <= CNT_W'(CAPACITY))

endmodule

bind bitmap_index_allocator bia_checker u_bia_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_status       (o_status),
    .o_result_index (o_result_index),
    .o_free_count   (o_free_count)
);

/* sim/tb_bitmap_index_allocator.sv */
module tb_bitmap_index_allocator;
    import bia_pkg::*;

    // Kinds of entries in the stimulus queue: a request word, a write of
    // active_count, or a pause until every reply has come back.
    typedef enum logic [1:0] {
        K_OP,
        K_CFG,
        K_SYNC
    } t_kind;

    typedef struct {
        t_kind             kind;
        logic              func;
        logic [IDX_W-1:0]  idx;
        logic [CNT_W-1:0]  cfg;
        int unsigned       gap;
    } t_stim;

    // One reply word as the allocator should report it.
    typedef struct {
        t_status           status;
        logic [IDX_W-1:0]  index;
        logic [CNT_W-1:0]  free_cnt;
    } t_reply;

    // Quiet cycles before a register write or the final check.
    localparam int unsigned SETTLE = 4;
    // Slowest run is roughly 2000 words, each with a full scan and the longest gap;
    // allow about ten times that.
    localparam int unsigned LIMIT  = 500000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              func = FUNC_ALLOC;
    logic [IDX_W-1:0]  entry_idx = '0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data = '0;
    logic              res_valid;
    logic [1:0]        res_status;
    logic [IDX_W-1:0]  res_index;
    logic [CNT_W-1:0]  res_free;

    bitmap_index_allocator dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (func),
        .i_entry_index  (entry_idx),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_result_valid (res_valid),
        .o_status       (res_status),
        .o_result_index (res_index),
        .o_free_count   (res_free)
    );

    t_stim        stim_q[$];
    t_reply       reply_q[$];

    // Shadow of the allocator: use flags, used count and active_count.
    bit           used_map [CAPACITY];
    int unsigned  used_total = 0;
    logic [CNT_W-1:0] active_reg = CNT_W'(CAPACITY);

    // Words sent is owned by the driver, replies seen by the monitor.
    int unsigned  n_sent = 0;
    int unsigned  n_seen = 0;
    int unsigned  errors = 0;
    int unsigned  cycles = 0;

    t_stim        cur;
    bit           loaded = 1'b0;
    int unsigned  wait_cnt = 0;
    int unsigned  quiet = 0;

    initial begin
        forever #1 clk = ~clk;
    end

    // Entries actually managed: active_count saturates at capacity.
    function automatic int unsigned managed();
        return (active_reg > CAPACITY) ? CAPACITY : int'(active_reg);
    endfunction

    // Free entries; a lowered active_count can leave more used than managed.
    function automatic int unsigned spare();
        int unsigned m;
        m = managed();
        return (m > used_total) ? m - used_total : 0;
    endfunction

    // Apply one request word to the shadow and queue the reply it owes.
    function automatic void serve_request(logic f, logic [IDX_W-1:0] idx);
        t_reply      r;
        int unsigned m;
        int unsigned i;
        bit          found;
        m        = managed();
        r.status = ST_OK;
        r.index  = '0;
        found    = 1'b0;
        if (f == FUNC_ALLOC) begin
            // First fit: lowest clear flag below the managed count, but only
            // when the free count says there is room.
            if (spare() != 0) begin
                for (i = 0; i < m && !found; i++) begin
                    if (!used_map[i]) begin
                        used_map[i] = 1'b1;
                        used_total++;
                        r.index = IDX_W'(i);
                        found   = 1'b1;
                    end
                end
            end
            if (!found) begin
                r.status = ST_FULL;
            end
        end else if (idx >= m || !used_map[idx]) begin
            r.status = ST_BAD;
        end else begin
            used_map[idx] = 1'b0;
            if (used_total > 0) begin
                used_total--;
            end
        end
        r.free_cnt = CNT_W'(spare());
        reply_q.push_back(r);
    endfunction

    function automatic void push_op(logic f, int unsigned idx, int unsigned gap);
        t_stim s;
        s.kind = K_OP;
        s.func = f;
        s.idx  = IDX_W'(idx);
        s.cfg  = '0;
        s.gap  = gap;
        stim_q.push_back(s);
    endfunction

    function automatic void push_cfg(int unsigned val);
        t_stim s;
        s.kind = K_CFG;
        s.func = FUNC_ALLOC;
        s.idx  = '0;
        s.cfg  = CNT_W'(val);
        s.gap  = 0;
        stim_q.push_back(s);
    endfunction

    function automatic void push_sync();
        t_stim s;
        s.kind = K_SYNC;
        s.func = FUNC_ALLOC;
        s.idx  = '0;
        s.cfg  = '0;
        s.gap  = 0;
        stim_q.push_back(s);
    endfunction

    // Driver: one decision per edge, one nonblocking write per signal.
    always @(posedge clk) begin : drive
        logic nxt_start;
        logic nxt_cfg_valid;
        int unsigned i;
        if (!rst_n) begin
            // Hold the inputs idle and clear the shadow with the block.
            for (i = 0; i < CAPACITY; i++) begin
                used_map[i] = 1'b0;
            end
            used_total = 0;
            active_reg = CNT_W'(CAPACITY);
            start     <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            nxt_start     = start;
            nxt_cfg_valid = cfg_valid;

            // Count idle cycles with no reply outstanding.
            if (n_sent == n_seen && !start && !cfg_valid) begin
                quiet++;
            end else begin
                quiet = 0;
            end

            // The word is taken at this edge: predict its reply now.
            if (start && !busy) begin
                serve_request(func, entry_idx);
                n_sent++;
                nxt_start = 1'b0;
            end

            if (cfg_valid && cfg_ready) begin
                active_reg    = cfg_data;
                nxt_cfg_valid = 1'b0;
            end

            // Advance to the next queue entry once the channels are free.
            if (!nxt_start && !nxt_cfg_valid) begin
                if (!loaded && stim_q.size() != 0) begin
                    cur      = stim_q.pop_front();
                    wait_cnt = cur.gap;
                    loaded   = 1'b1;
                end
                if (loaded) begin
                    case (cur.kind)
                        K_OP: begin
                            if (wait_cnt == 0) begin
                                nxt_start = 1'b1;
                                func      <= cur.func;
                                entry_idx <= cur.idx;
                                loaded    = 1'b0;
                            end else begin
                                wait_cnt--;
                            end
                        end
                        K_CFG: begin
                            // Write the register only with the block idle.
                            if (quiet >= SETTLE) begin
                                nxt_cfg_valid = 1'b1;
                                cfg_data      <= cur.cfg;
                                loaded        = 1'b0;
                            end
                        end
                        default: begin
                            if (quiet >= SETTLE) begin
                                loaded = 1'b0;
                            end
                        end
                    endcase
                end
            end

            start     <= nxt_start;
            cfg_valid <= nxt_cfg_valid;
        end
    end

    // Monitor: a reply is on the ports for one cycle only; take it here.
    always @(posedge clk) begin : check
        t_reply want;
        if (rst_n && res_valid) begin
            if (reply_q.size() == 0) begin
                errors++;
                $display("%0t unexpected reply: status %0d index %0d free %0d",
                         $time, res_status, res_index, res_free);
            end else begin
                want = reply_q.pop_front();
                if (res_status !== want.status) begin
                    errors++;
                    $display("%0t status mismatch: expected %0d, actual %0d",
                             $time, want.status, res_status);
                end
                if (res_index !== want.index) begin
                    errors++;
                    $display("%0t index mismatch: expected %0d, actual %0d",
                             $time, want.index, res_index);
                end
                if (res_free !== want.free_cnt) begin
                    errors++;
                    $display("%0t free count mismatch: expected %0d, actual %0d",
                             $time, want.free_cnt, res_free);
                end
                n_seen <= n_seen + 1;
            end
        end
    end

    // Watchdog: drop the run if it hangs.
    always @(posedge clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned n_ops;
        int unsigned act;
        int unsigned eff;
        int unsigned len;
        int unsigned weight;
        int unsigned hi;
        int unsigned k;
        int unsigned top;
        bit          calm;

        // Directed: clear and empty frees, first fit reuse, double free,
        // nothing managed, saturated count, count lowered below the used
        // entries, and a single managed entry.
        push_op(FUNC_FREE, 0, $urandom_range(0, 3));
        push_op(FUNC_FREE, 1023, $urandom_range(0, 3));
        push_op(FUNC_ALLOC, 0, 0);
        push_op(FUNC_ALLOC, 1023, 0);
        push_op(FUNC_ALLOC, 0, $urandom_range(0, 3));
        push_op(FUNC_FREE, 1, 0);
        push_op(FUNC_ALLOC, 0, $urandom_range(0, 3));
        push_op(FUNC_FREE, 1, 0);
        push_op(FUNC_FREE, 1, 0);
        push_sync();
        push_cfg(0);
        push_op(FUNC_ALLOC, 0, 0);
        push_op(FUNC_FREE, 0, $urandom_range(0, 3));
        push_cfg(2047);
        push_op(FUNC_ALLOC, 0, 0);
        push_op(FUNC_ALLOC, 0, 0);
        push_cfg(2);
        push_op(FUNC_ALLOC, 0, 0);
        push_op(FUNC_FREE, 3, $urandom_range(0, 3));
        push_op(FUNC_FREE, 0, 0);
        push_op(FUNC_ALLOC, 0, 0);
        push_cfg(1);
        push_op(FUNC_FREE, 0, 0);
        push_op(FUNC_ALLOC, 0, 0);
        push_cfg(1024);
        push_op(FUNC_FREE, 2, 0);
        push_op(FUNC_FREE, 3, $urandom_range(0, 3));
        push_op(FUNC_FREE, 1, 0);
        push_cfg(1);
        push_op(FUNC_ALLOC, 0, 0);
        push_op(FUNC_ALLOC, 0, 0);
        push_op(FUNC_FREE, 0, 0);
        n_ops = 25;

        // Fill phase: mostly allocates over the full map so the scan reaches
        // the upper words and the map runs full; switch idling every 64 words.
        push_cfg(1024);
        hi   = 0;
        calm = 1'b0;
        for (k = 0; k < 1100; k++) begin
            if (k % 64 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 99) < 94) begin
                push_op(FUNC_ALLOC, $urandom_range(0, 1023),
                        calm ? 0 : $urandom_range(0, 9));
                if (hi < 1023) begin
                    hi++;
                end
            end else begin
                push_op(FUNC_FREE, $urandom_range(0, hi),
                        calm ? 0 : $urandom_range(0, 9));
            end
            if (k == 600) begin
                push_sync();
            end
        end
        n_ops += 1100;

        // Mixed phases: fresh active_count each time, extremes included.
        while (n_ops < 1850) begin
            case ($urandom_range(0, 9))
                0:       act = 0;
                1:       act = 1;
                2:       act = 2047;
                3:       act = 1024;
                4:       act = $urandom_range(1025, 2047);
                5, 6:    act = $urandom_range(1, 64);
                default: act = $urandom_range(1, 1024);
            endcase
            push_cfg(act);
            eff    = (act > CAPACITY) ? CAPACITY : act;
            len    = $urandom_range(20, 200);
            weight = $urandom_range(30, 90);
            calm   = ($urandom_range(0, 3) == 0);
            for (k = 0; k < len; k++) begin
                if ($urandom_range(0, 99) < weight) begin
                    push_op(FUNC_ALLOC, $urandom_range(0, 1023),
                            calm ? 0 : $urandom_range(0, 9));
                end else begin
                    // Aim frees mostly at entries likely to be taken.
                    if ($urandom_range(0, 7) == 0) begin
                        top = 1023;
                    end else if (eff != 0 && $urandom_range(0, 1) == 0) begin
                        top = eff - 1;
                    end else begin
                        top = hi;
                    end
                    push_op(FUNC_FREE, $urandom_range(0, top),
                            calm ? 0 : $urandom_range(0, 9));
                end
                if (k == len / 2 && $urandom_range(0, 2) == 0) begin
                    push_sync();
                end
            end
            n_ops += len;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all words sent, every reply back, then a few quiet cycles.
        while (stim_q.size() != 0 || loaded || start || cfg_valid) begin
            @(negedge clk);
        end
        while (n_seen != n_sent) begin
            @(negedge clk);
        end
        repeat (SETTLE * 4) @(negedge clk);
        if (reply_q.size() != 0) begin
            errors++;
            $display("%0t %0d replies never arrived", $time, reply_q.size());
        end

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
